FILE: design/cstrip_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the C comment stripper.
// No dependencies; imported by c_comment_stripper.
package cstrip_pkg;

  // Parser mode codes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_STRING = 3'd1;
  localparam logic [2:0] MODE_CHAR   = 3'd2;
  localparam logic [2:0] MODE_BLOCK  = 3'd3;
  localparam logic [2:0] MODE_LINE   = 3'd4;
  localparam logic [2:0] MODE_ESCAPE = 3'd5;

  // Character codes
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Register indexes
  localparam logic REG_STRIP_BLOCK = 1'b0;
  localparam logic REG_STRIP_LINE  = 1'b1;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       last;
  } result_t;

endpackage

FILE: design/c_comment_stripper.sv
`timescale 1ns / 1ps
// C comment stripper: drops block and/or line comments from a byte stream.
// Depends on cstrip_pkg for mode codes, character codes and the result type.
//
// Usage:
//   Input channel in_valid/in_ready carries one source byte (in_byte) per
//   item, with in_last on the final byte of a file. Output channel
//   out_valid/out_ready carries out_byte, byte_valid and out_last; an item
//   that releases no byte on the last input gives one marker result with
//   byte_valid low and out_last high.
//   The parse decision for an item is made in the cycle it is accepted and
//   its zero, one or two results are written to a four-entry result queue;
//   the output shows the registered queue head, draining one result a
//   cycle while out_ready is high. Throughput is one input item per cycle
//   while in_ready is high, which is while the queue has room for two
//   results; the queue depth sets how long input flows when the receiver
//   stalls, and a stalled receiver fills the queue, then holds in_ready low.
//   Registers strip_block (address 0) and strip_line (address 4) are set
//   over the APB port; pready is always high.
//   Reset (rst, synchronous) empties the queue, returns the parser to
//   normal code and clears both registers.
module c_comment_stripper
  import cstrip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  logic       strip_block;
  logic       strip_line;
  logic [2:0] mode;
  logic       escape_return;
  logic       held_slash;
  logic       held_star;

  logic [2:0] mode_next;
  logic       escape_return_next;
  logic       held_slash_next;
  logic       held_star_next;

  result_t    queue [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  logic       in_fire;
  logic       out_fire;
  logic       cfg_write;

  // Plain byte handling
  logic       p_emit;
  logic [2:0] p_mode;
  logic       p_esc;
  logic       p_hslash;
  logic       p_hstar;

  // Item decision
  logic       pre_emit;
  logic [7:0] pre_byte;
  logic       use_plain;
  logic [1:0] n_res;
  result_t    res0;
  result_t    res1;
  logic [QAW-1:0] wr_ptr1;

  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid & out_ready;
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign in_ready  = (count <= (QAW+1)'(QDEPTH - 2));
  assign out_valid = (count != '0);
  assign out_byte   = queue[rd_ptr].data;
  assign byte_valid = queue[rd_ptr].bvalid;
  assign out_last   = queue[rd_ptr].last;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_STRIP_BLOCK) begin
      prdata[0] = strip_block;
    end else begin
      prdata[0] = strip_line;
    end
  end

  always_comb begin
    p_emit   = 1'b0;
    p_mode   = mode;
    p_esc    = escape_return;
    p_hslash = 1'b0;
    p_hstar  = 1'b0;
    case (mode)
      MODE_ESCAPE: begin
        p_emit = 1'b1;
        p_mode = escape_return ? MODE_CHAR : MODE_STRING;
      end
      MODE_STRING: begin
        p_emit = 1'b1;
        if (in_byte == CH_BSLASH) begin
          p_esc  = 1'b0;
          p_mode = MODE_ESCAPE;
        end else if (in_byte == CH_DQUOTE) begin
          p_mode = MODE_NORMAL;
        end
      end
      MODE_CHAR: begin
        p_emit = 1'b1;
        if (in_byte == CH_BSLASH) begin
          p_esc  = 1'b1;
          p_mode = MODE_ESCAPE;
        end else if (in_byte == CH_SQUOTE) begin
          p_mode = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (in_byte == CH_STAR && !in_last) begin
          p_hstar = 1'b1;
        end else begin
          p_emit = ~strip_block;
        end
      end
      MODE_LINE: begin
        p_emit = ~strip_line | (in_byte == CH_NEWLINE);
        if (in_byte == CH_NEWLINE) begin
          p_mode = MODE_NORMAL;
        end
      end
      default: begin
        p_mode = MODE_NORMAL;
        if (in_byte == CH_SLASH && (strip_block | strip_line) && !in_last) begin
          p_hslash = 1'b1;
        end else begin
          p_emit = 1'b1;
          if (in_byte == CH_DQUOTE) begin
            p_mode = MODE_STRING;
          end else if (in_byte == CH_SQUOTE) begin
            p_mode = MODE_CHAR;
          end
        end
      end
    endcase
  end

  always_comb begin
    pre_emit           = 1'b0;
    pre_byte           = CH_SLASH;
    use_plain          = 1'b1;
    mode_next          = p_mode;
    escape_return_next = p_esc;
    held_slash_next    = p_hslash;
    held_star_next     = p_hstar;

    if (held_slash) begin
      if (in_byte == CH_STAR && strip_block) begin
        use_plain = 1'b0;
        mode_next = MODE_BLOCK;
      end else if (in_byte == CH_SLASH && strip_line) begin
        use_plain = 1'b0;
        mode_next = MODE_LINE;
      end else begin
        pre_emit = 1'b1;
      end
    end else if (held_star) begin
      pre_byte = CH_STAR;
      if (in_byte == CH_SLASH) begin
        use_plain = 1'b0;
        mode_next = MODE_NORMAL;
      end else begin
        pre_emit = ~strip_block;
      end
    end

    if (!use_plain) begin
      escape_return_next = escape_return;
      held_slash_next    = 1'b0;
      held_star_next     = 1'b0;
    end

    n_res       = {1'b0, pre_emit} + {1'b0, use_plain & p_emit};
    res0.data   = pre_emit ? pre_byte : in_byte;
    res0.bvalid = 1'b1;
    res0.last   = 1'b0;
    res1.data   = in_byte;
    res1.bvalid = 1'b1;
    res1.last   = 1'b0;

    if (in_last) begin
      // flush: mark the final result, or give an empty marker
      if (n_res == 2'd0) begin
        n_res       = 2'd1;
        res0.data   = '0;
        res0.bvalid = 1'b0;
      end
      if (n_res == 2'd2) begin
        res1.last = 1'b1;
      end else begin
        res0.last = 1'b1;
      end
      mode_next          = MODE_NORMAL;
      escape_return_next = 1'b0;
      held_slash_next    = 1'b0;
      held_star_next     = 1'b0;
    end
  end

  assign wr_ptr1 = wr_ptr + QAW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_block   <= 1'b0;
      strip_line    <= 1'b0;
      mode          <= MODE_NORMAL;
      escape_return <= 1'b0;
      held_slash    <= 1'b0;
      held_star     <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == REG_STRIP_BLOCK) begin
          strip_block <= pwdata[0];
        end else begin
          strip_line <= pwdata[0];
        end
      end
      if (in_fire) begin
        mode          <= mode_next;
        escape_return <= escape_return_next;
        held_slash    <= held_slash_next;
        held_star     <= held_star_next;
        wr_ptr        <= wr_ptr + QAW'(n_res);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + (QAW+1)'(in_fire ? n_res : 2'd0) - (QAW+1)'(out_fire);
    end
  end

  // Result queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (n_res != 2'd0) begin
        queue[wr_ptr] <= res0;
      end
      if (n_res == 2'd2) begin
        queue[wr_ptr1] <= res1;
      end
    end
  end

endmodule
